// File: rtl/core/gae_advantage_recurrence_macros.svh
// Assertion macros for the advantage recurrence block.
// GAE_ASSERT_NOW: the consequent holds in the same cycle as the antecedent.
// GAE_ASSERT_NEXT: the consequent holds in the cycle after the antecedent.
`ifndef GAE_ADVANTAGE_RECURRENCE_MACROS_SVH
`define GAE_ADVANTAGE_RECURRENCE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define GAE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gae: same-cycle check failed");

`define GAE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gae: next-cycle check failed");

`else

`define GAE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define GAE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/gae_pkg.sv
`default_nettype none

package gae_pkg;

    localparam int NUM_ENVS  = 16;
    localparam int SLOT_W    = (NUM_ENVS > 1) ? $clog2(NUM_ENVS) : 1;
    localparam int DATA_W    = 32;
    localparam int WGT_W     = 17;
    localparam int ENV_W     = 4;
    localparam int OPB_W     = DATA_W + 1;
    localparam int PROD_W    = WGT_W + 1 + OPB_W;
    localparam int RND_W     = PROD_W - 16;
    localparam int SUM_W     = RND_W + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [WGT_W-1:0] Q_ONE        = 17'd65536;
    localparam logic [WGT_W-1:0] DISCOUNT_RST = 17'd64880;
    localparam logic [WGT_W-1:0] TRACE_RST    = 17'd62259;

    localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(32768);
    localparam logic signed [SUM_W-1:0]  SAT_MAX  = SUM_W'(64'sh7FFF_FFFF);
    localparam logic signed [SUM_W-1:0]  SAT_MIN  = -SUM_W'(64'sh8000_0000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISCOUNT    = 2'd0,
        CFG_TRACE_DECAY = 2'd1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GB,
        S_GL,
        S_T1,
        S_GLC,
        S_HOLD,
        S_T2,
        S_ADV,
        S_FIN
    } t_state;

    // Operands for the shared multiplier: unsigned weight times signed word.
    typedef struct packed {
        logic        [WGT_W-1:0] a;
        logic signed [OPB_W-1:0] b;
    } t_mul_op;

    function automatic logic [WGT_W-1:0] wclamp(input logic [WGT_W-1:0] w);
        return (w > Q_ONE) ? Q_ONE : w;
    endfunction

    // Round a Q.16 product to nearest, ties toward plus infinity.
    function automatic logic signed [RND_W-1:0] round_q16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] b;
        b = p + HALF_LSB;
        return b[PROD_W-1:16];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] c;
        c = (x > SAT_MAX) ? SAT_MAX : ((x < SAT_MIN) ? SAT_MIN : x);
        return c[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/gae_mul.sv
`default_nettype none

// Shared multiplier: register the product, round it on the way out.
module gae_mul import gae_pkg::*; (
    input  logic                     i_clk,
    input  t_mul_op                  i_op,
    output logic signed [RND_W-1:0]  o_rnd
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= $signed({1'b0, i_op.a}) * i_op.b;
    end

    assign o_rnd = round_q16(r_prod);

endmodule

`default_nettype wire

// File: rtl/core/gae_advantage_recurrence.sv
`default_nettype none
//  channel  direction  handshake                    payload
//  in       to block   i_in_valid / o_in_stall      reward, value, next_value, bootstrap,
//                                                   continuation, env_index, first_sample
//  out      from block o_out_valid / i_out_stall    advantage, return_value, env_echo
//  cfg      to block   i_cfg_we                     i_cfg_idx, i_cfg_data
//
//  Each item runs from the accept cycle through eight sequencer steps that
//  share one 18x33 multiplier for five dependent products.
//  The last step waits while the output register still holds an untaken item.
//  Reset (synchronous, active low) restores the register defaults and clears
//  the per-environment valid bits, so every accumulator reads as zero.
//  o_in_stall is high whenever the sequencer is busy.
`include "gae_advantage_recurrence_macros.svh"

module gae_advantage_recurrence import gae_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [DATA_W-1:0] i_reward,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic signed [DATA_W-1:0] i_next_value,
    input  logic        [WGT_W-1:0]  i_bootstrap,
    input  logic        [WGT_W-1:0]  i_continuation,
    input  logic        [ENV_W-1:0]  i_env_index,
    input  logic                     i_first_sample,
    // output channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_advantage,
    output logic signed [DATA_W-1:0] o_return_value,
    output logic        [ENV_W-1:0]  o_env_echo,
    // configuration
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [WGT_W-1:0]         i_cfg_data
);

    // Configuration registers, stored raw and clamped where they are used.
    logic [WGT_W-1:0] r_discount;
    logic [WGT_W-1:0] r_trace;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_discount <= DISCOUNT_RST;
            r_trace    <= TRACE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DISCOUNT:    r_discount <= i_cfg_data;
                CFG_TRACE_DECAY: r_trace    <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    logic [WGT_W-1:0] g_w;
    logic [WGT_W-1:0] l_w;
    assign g_w = wclamp(r_discount);
    assign l_w = wclamp(r_trace);

    // Sequencer
    t_state r_state, n_state;
    logic   in_acc;
    logic   fin_load;
    logic   acc_we;
    t_mul_op mul_op;
    logic signed [RND_W-1:0] rnd;

    // Latched item
    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] r_next_value;
    logic signed [DATA_W:0]   r_diff;       // reward - value
    logic        [WGT_W-1:0]  r_boot;
    logic        [WGT_W-1:0]  r_cont;
    logic        [ENV_W-1:0]  r_env;
    logic                     r_first;
    logic        [SLOT_W-1:0] r_slot;

    // Intermediates
    logic        [WGT_W-1:0]  r_gb;
    logic        [WGT_W-1:0]  r_gl;
    logic        [WGT_W-1:0]  r_glc;
    logic signed [RND_W-1:0]  r_delta;
    logic signed [DATA_W-1:0] r_adv;
    logic signed [DATA_W-1:0] n_adv;
    logic signed [DATA_W-1:0] acc_op;

    // Accumulator store with one valid bit per environment.
    logic signed [DATA_W-1:0] r_acc_mem [NUM_ENVS];
    logic [NUM_ENVS-1:0]      r_acc_vld;
    logic signed [DATA_W-1:0] r_acc_rd;
    logic                     r_acc_hit;
    logic [SLOT_W-1:0]        slot_in;

    // Output register
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_adv_out;
    logic signed [DATA_W-1:0] r_ret_out;
    logic        [ENV_W-1:0]  r_env_out;

    assign slot_in = i_env_index[SLOT_W-1:0];
    assign in_acc  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: a fixed walk through the products, then deliver.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_GB;
            S_GB:   n_state = S_GL;
            S_GL:   n_state = S_T1;
            S_T1:   n_state = S_GLC;
            S_GLC:  n_state = S_HOLD;
            S_HOLD: n_state = S_T2;
            S_T2:   n_state = S_ADV;
            S_ADV:  n_state = S_FIN;
            S_FIN:  if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign acc_op = (r_first || !r_acc_hit) ? '0 : r_acc_rd;

    // Outputs of the sequencer: multiplier operands and strobes.
    always_comb begin
        o_in_stall = 1'b1;
        fin_load   = 1'b0;
        acc_we     = 1'b0;
        mul_op.a   = '0;
        mul_op.b   = '0;
        case (r_state)
            S_IDLE: o_in_stall = 1'b0;
            S_GB: begin
                mul_op.a = g_w;
                mul_op.b = {{(OPB_W-WGT_W){1'b0}}, r_boot};
            end
            S_GL: begin
                mul_op.a = g_w;
                mul_op.b = {{(OPB_W-WGT_W){1'b0}}, l_w};
            end
            S_T1: begin
                mul_op.a = r_gb;
                mul_op.b = OPB_W'(r_next_value);
            end
            S_GLC: begin
                mul_op.a = r_gl;
                mul_op.b = {{(OPB_W-WGT_W){1'b0}}, r_cont};
            end
            S_T2: begin
                mul_op.a = r_glc;
                mul_op.b = OPB_W'(acc_op);
            end
            S_ADV:  acc_we   = 1'b1;
            S_FIN:  fin_load = !r_out_valid || !i_out_stall;
            default: ;
        endcase
    end

    gae_mul u_mul (
        .i_clk (i_clk),
        .i_op  (mul_op),
        .o_rnd (rnd)
    );

    assign n_adv = sat32(SUM_W'(r_delta) + SUM_W'(rnd));

    // Datapath: capture the item, then take each rounded product as it lands.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_value      <= i_value;
            r_next_value <= i_next_value;
            r_diff       <= (DATA_W+1)'(i_reward) - (DATA_W+1)'(i_value);
            r_boot       <= wclamp(i_bootstrap);
            r_cont       <= wclamp(i_continuation);
            r_env        <= i_env_index;
            r_first      <= i_first_sample;
            r_slot       <= slot_in;
        end
        case (r_state)
            S_GL:   r_gb    <= rnd[WGT_W-1:0];
            S_T1:   r_gl    <= rnd[WGT_W-1:0];
            S_GLC:  r_delta <= RND_W'(r_diff) + rnd;
            S_HOLD: r_glc   <= rnd[WGT_W-1:0];
            S_ADV:  r_adv   <= n_adv;
            default: ;
        endcase
    end

    // Store: read on accept, write back the new advantage.
    always_ff @(posedge i_clk) begin
        if (acc_we) begin
            r_acc_mem[r_slot] <= n_adv;
        end
        if (in_acc) begin
            r_acc_rd <= r_acc_mem[slot_in];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld <= '0;
            r_acc_hit <= 1'b0;
        end else begin
            if (acc_we) begin
                r_acc_vld[r_slot] <= 1'b1;
            end
            if (in_acc) begin
                r_acc_hit <= r_acc_vld[slot_in];
            end
        end
    end

    // Output register: load on the last step, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_load) begin
            r_adv_out <= r_adv;
            r_ret_out <= sat32(SUM_W'(r_adv) + SUM_W'(r_value));
            r_env_out <= r_env;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_advantage    = r_adv_out;
    assign o_return_value = r_ret_out;
    assign o_env_echo     = r_env_out;

    `GAE_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, in_acc, r_state == S_GB)
    `GAE_ASSERT_NEXT(a_fin_delivers, i_clk, i_rst_n, fin_load, r_out_valid && (r_env_out == $past(r_env)))
    `GAE_ASSERT_NEXT(a_adv_written, i_clk, i_rst_n, acc_we, r_acc_vld[r_slot] && (r_acc_mem[r_slot] == r_adv))
    `GAE_ASSERT_NOW(a_weights_clamped, i_clk, i_rst_n, r_state != S_IDLE, (r_boot <= Q_ONE) && (r_cont <= Q_ONE))

endmodule

`default_nettype wire

// File: tb/sv/tb_gae_advantage_recurrence.sv
`default_nettype none

module tb_gae_advantage_recurrence;
    import gae_pkg::*;

    // Run limit in time units; far above the slowest correct run.
    localparam int unsigned RUN_LIMIT    = 2_000_000;
    // Cycles to wait once the last result is in, so the sequencer is idle.
    localparam int          DRAIN_CYCLES = 12;

    localparam logic signed [DATA_W-1:0] Q16_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q16_MIN = 32'sh8000_0000;
    localparam logic        [WGT_W-1:0]  W_TOP   = 17'h1_FFFF;

    // Indexes with no register behind them.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = 2'd3;

    typedef struct {
        logic signed [DATA_W-1:0] reward;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] next_value;
        logic        [WGT_W-1:0]  bootstrap;
        logic        [WGT_W-1:0]  continuation;
        logic        [ENV_W-1:0]  env;
        logic                     first_step;
    } t_gae_sample;

    typedef struct {
        logic signed [DATA_W-1:0] advantage;
        logic signed [DATA_W-1:0] return_value;
        logic        [ENV_W-1:0]  env;
    } t_gae_result;

    typedef enum {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic signed [DATA_W-1:0] reward = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic signed [DATA_W-1:0] next_value = '0;
    logic        [WGT_W-1:0]  bootstrap = '0;
    logic        [WGT_W-1:0]  continuation = '0;
    logic        [ENV_W-1:0]  env_index = '0;
    logic                     first_sample = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] advantage;
    logic signed [DATA_W-1:0] return_value;
    logic        [ENV_W-1:0]  env_echo;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_idx = '0;
    logic [WGT_W-1:0]         cfg_data = '0;

    // Shadow of the block: weight registers and per-environment accumulators.
    logic        [WGT_W-1:0]  gamma_q;
    logic        [WGT_W-1:0]  lambda_q;
    logic signed [DATA_W-1:0] adv_store [NUM_ENVS];

    t_gae_result expected_advantages [$];
    int          fail_count = 0;
    int          burst_left = 0;
    int          steps_left [NUM_ENVS] = '{default: 0};
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_left = 0;

    gae_advantage_recurrence dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_reward       (reward),
        .i_value        (value),
        .i_next_value   (next_value),
        .i_bootstrap    (bootstrap),
        .i_continuation (continuation),
        .i_env_index    (env_index),
        .i_first_sample (first_sample),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_advantage    (advantage),
        .o_return_value (return_value),
        .o_env_echo     (env_echo),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #(RUN_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // ---------------------------------------------------------------
    // Fixed-point arithmetic of the recurrence, kept exact in 64 bits.
    // ---------------------------------------------------------------
    function automatic longint unit_clamp(input logic [WGT_W-1:0] w);
        return (w > Q_ONE) ? longint'(Q_ONE) : longint'(w);
    endfunction

    // Round a product with 16 fraction bits to nearest, ties upward.
    function automatic longint rnd_q16(input longint p);
        return (p + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clip32(input longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    // Work out one sample's result and advance that environment's accumulator.
    function automatic t_gae_result next_advantage(input t_gae_sample s);
        longint      gb, gl, glc, carry, delta, adv, ret;
        int          slot;
        t_gae_result r;
        slot  = int'(s.env) % NUM_ENVS;
        gb    = rnd_q16(unit_clamp(gamma_q) * unit_clamp(s.bootstrap));
        delta = longint'(s.reward) + rnd_q16(gb * longint'(s.next_value))
                - longint'(s.value);
        gl    = rnd_q16(unit_clamp(gamma_q) * unit_clamp(lambda_q));
        glc   = rnd_q16(gl * unit_clamp(s.continuation));
        carry = s.first_step ? 64'sd0 : longint'(adv_store[slot]);
        adv   = clip32(delta + rnd_q16(glc * carry));
        ret   = clip32(adv + longint'(s.value));
        adv_store[slot]  = adv[DATA_W-1:0];
        r.advantage      = adv[DATA_W-1:0];
        r.return_value   = ret[DATA_W-1:0];
        r.env            = s.env;
        return r;
    endfunction

    function automatic t_gae_sample mk(input logic signed [DATA_W-1:0] rw,
                                       input logic signed [DATA_W-1:0] v,
                                       input logic signed [DATA_W-1:0] nv,
                                       input logic [WGT_W-1:0] bw,
                                       input logic [WGT_W-1:0] cw,
                                       input logic [ENV_W-1:0] e,
                                       input logic f);
        t_gae_sample s;
        s.reward       = rw;
        s.value        = v;
        s.next_value   = nv;
        s.bootstrap    = bw;
        s.continuation = cw;
        s.env          = e;
        s.first_step   = f;
        return s;
    endfunction

    // Mostly realistic magnitudes, now and then the whole word.
    function automatic logic signed [DATA_W-1:0] rand_q16();
        logic signed [DATA_W-1:0] w;
        w = $urandom;
        if ($urandom_range(0, 9) == 0)
            return w;
        return w >>> $urandom_range(6, 22);
    endfunction

    // ---------------------------------------------------------------
    // Input side: bursts of items with random gaps in between.
    // ---------------------------------------------------------------
    task automatic send_sample(input t_gae_sample s);
        in_valid     <= 1'b1;
        reward       <= s.reward;
        value        <= s.value;
        next_value   <= s.next_value;
        bootstrap    <= s.bootstrap;
        continuation <= s.continuation;
        env_index    <= s.env;
        first_sample <= s.first_step;
        do @(posedge clk); while (in_stall);
        expected_advantages.push_back(next_advantage(s));
        // Keep valid high inside a burst; drop it for a gap at the end of one.
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // Drop valid, wait for every expected result, then let the block settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_advantages.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WGT_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_DISCOUNT:    gamma_q = data;
            CFG_TRACE_DECAY: lambda_q = data;
            default: ;  // drop writes to unmapped indexes
        endcase
    endtask

    task automatic configure(input logic [WGT_W-1:0] g, input logic [WGT_W-1:0] l);
        drain_results();
        write_reg(CFG_DISCOUNT, g);
        write_reg(CFG_TRACE_DECAY, l);
    endtask

    // Next step of a rollout for a random environment, opened with a first flag.
    function automatic t_gae_sample rollout_sample();
        t_gae_sample s;
        int          e;
        e = $urandom_range(0, NUM_ENVS - 1);
        s.env        = e[ENV_W-1:0];
        s.first_step = (steps_left[e] == 0);
        if (s.first_step)
            steps_left[e] = $urandom_range(1, 24);
        else
            steps_left[e]--;
        s.reward     = rand_q16();
        s.value      = rand_q16();
        s.next_value = rand_q16();
        s.bootstrap  = ($urandom_range(0, 6) == 0) ? '0 : Q_ONE;
        if (s.first_step)
            s.continuation = ($urandom_range(0, 1) == 0) ? '0 : Q_ONE;
        else if ($urandom_range(0, 9) == 0)
            s.continuation = WGT_W'($urandom_range(0, Q_ONE));
        else
            s.continuation = Q_ONE;
        return s;
    endfunction

    function automatic t_gae_sample noise_sample();
        t_gae_sample s;
        s.reward       = $urandom;
        s.value        = $urandom;
        s.next_value   = $urandom;
        s.bootstrap    = WGT_W'($urandom_range(0, W_TOP));
        s.continuation = WGT_W'($urandom_range(0, W_TOP));
        s.env          = ENV_W'($urandom_range(0, NUM_ENVS - 1));
        s.first_step   = 1'($urandom_range(0, 1));
        return s;
    endfunction

    // ---------------------------------------------------------------
    // Output side: stall on a pattern that changes mode now and then.
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= ((stall_left % 7) < 3);
        endcase
    end

    // Compare every taken result with the oldest expectation.
    always @(posedge clk) begin : check_results
        t_gae_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_advantages.size() == 0) begin
                $error("result with nothing expected: env_echo %0d", env_echo);
                fail_count++;
            end else begin
                want = expected_advantages.pop_front();
                if (advantage !== want.advantage) begin
                    $error("advantage: expected %0d, got %0d", want.advantage, advantage);
                    fail_count++;
                end
                if (return_value !== want.return_value) begin
                    $error("return_value: expected %0d, got %0d",
                           want.return_value, return_value);
                    fail_count++;
                end
                if (env_echo !== want.env) begin
                    $error("env_echo: expected %0d, got %0d", want.env, env_echo);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Field extremes, saturation both ways, weights above one and the first flag,
    // all under the reset weights.
    task automatic test_directed_extremes();
        send_sample(mk(0, 0, 0, '0, '0, 4'd0, 1'b1));
        send_sample(mk(Q16_MAX, 0, 0, '0, Q_ONE, 4'd0, 1'b0));
        // carry a full accumulator: the advantage saturates high
        send_sample(mk(Q16_MAX, 0, 0, '0, Q_ONE, 4'd0, 1'b0));
        // the return saturates high on top of that
        send_sample(mk(Q16_MAX, 32'sh4000_0000, 0, '0, Q_ONE, 4'd0, 1'b0));
        // delta below the range: advantage saturates low
        send_sample(mk(Q16_MIN, Q16_MAX, 0, '0, '0, 4'd1, 1'b1));
        send_sample(mk(Q16_MIN, 32'shC000_0000, 0, '0, Q_ONE, 4'd1, 1'b0));
        send_sample(mk(0, 0, Q16_MAX, Q_ONE, '0, 4'd2, 1'b1));
        send_sample(mk(0, 0, Q16_MIN, Q_ONE, '0, 4'd3, 1'b1));
        // bootstrap weights above one clamp to one
        send_sample(mk(0, 0, Q16_MAX, W_TOP, '0, 4'd4, 1'b1));
        send_sample(mk(0, 0, Q16_MIN, 17'd65537, '0, 4'd5, 1'b1));
        // continuation above one clamps too
        send_sample(mk(32'sh0001_0000, 0, 0, '0, W_TOP, 4'd4, 1'b0));
        send_sample(mk(32'sh0001_0000, 0, 0, '0, '0, 4'd5, 1'b0));
        // first flag drops a nonzero accumulator
        send_sample(mk(0, 0, 0, '0, Q_ONE, 4'd4, 1'b1));
        send_sample(mk(-1, 1, -1, 17'd1, 17'd1, 4'd15, 1'b1));
        send_sample(mk(32'sh0000_8000, Q16_MIN, 32'shFFFF_8000, 17'd32768, Q_ONE, 4'd15, 1'b0));
    endtask

    // Both registers at zero, one and beyond one, a few items under each.
    task automatic test_register_extremes();
        logic [WGT_W-1:0] gammas  [4];
        logic [WGT_W-1:0] lambdas [4];
        gammas  = '{'0, Q_ONE, W_TOP, Q_ONE};
        lambdas = '{'0, Q_ONE, W_TOP, '0};
        for (int k = 0; k < 4; k++) begin
            configure(gammas[k], lambdas[k]);
            send_sample(mk(32'sh0002_4000, 32'shFFFF_2000, 32'sh0010_0001, Q_ONE, '0, 4'd6, 1'b1));
            send_sample(mk(32'sh0002_4000, 32'shFFFF_2000, 32'sh0010_0001, Q_ONE, Q_ONE, 4'd6,
                           1'b0));
            send_sample(mk(32'shFFF0_0000, 32'sh0003_0000, 32'sh7000_0000, W_TOP, W_TOP, 4'd6,
                           1'b0));
        end
    endtask

    // Writes to unmapped indexes must leave both weights as they were.
    task automatic test_unknown_register();
        drain_results();
        write_reg(CFG_UNMAPPED_A, '0);
        write_reg(CFG_UNMAPPED_B, W_TOP);
        send_sample(mk(32'sh0001_0000, 32'sh0000_4000, 32'sh0002_0000, Q_ONE, '0, 4'd7, 1'b1));
        send_sample(mk(32'sh0001_0000, 32'sh0000_4000, 32'sh0002_0000, Q_ONE, Q_ONE, 4'd7, 1'b0));
    endtask

    // Interleaved rollouts with random content and some noise, over several settings.
    task automatic test_random_rollouts();
        t_gae_sample s;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: configure(DISCOUNT_RST, TRACE_RST);
                1: configure(WGT_W'($urandom_range(0, Q_ONE)),
                             WGT_W'($urandom_range(0, Q_ONE)));
                2: configure(Q_ONE, Q_ONE);
                3: configure(WGT_W'($urandom_range(0, W_TOP)),
                             WGT_W'($urandom_range(0, W_TOP)));
                default: configure('0, Q_ONE);
            endcase
            for (int n = 0; n < 130; n++) begin
                if ($urandom_range(0, 4) == 0)
                    s = noise_sample();
                else
                    s = rollout_sample();
                send_sample(s);
            end
        end
    endtask

    initial begin
        gamma_q  = DISCOUNT_RST;
        lambda_q = TRACE_RST;
        foreach (adv_store[e])
            adv_store[e] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_register_extremes();
        test_unknown_register();
        test_random_rollouts();
        drain_results();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
